>>> src/ofp_pkg.sv
// ofp_pkg: shared types, constants and the address lookup for the osc audio frame parser
// no dependencies; imported by every module of the block
`default_nettype none

package ofp_pkg;

	localparam int MaxPacketBytes = 1024;
	localparam int TakenW         = $clog2(MaxPacketBytes + 1);

	localparam logic [5:0] AddrLen   = 6'd12;
	localparam logic [5:0] TagLen    = 6'd25;
	localparam logic [5:0] LenMax    = 6'd63;
	localparam logic [4:0] WordCount = 5'd24;
	localparam logic [7:0] TagComma  = 8'h2c;

	localparam int QueueDepth = 4;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	// result kinds
	localparam logic KindWord   = 1'b0;
	localparam logic KindStatus = 1'b1;

	// frame status codes
	localparam logic [1:0] StatOk        = 2'd0;
	localparam logic [1:0] StatBadAddr   = 2'd1;
	localparam logic [1:0] StatBadTag    = 2'd2;
	localparam logic [1:0] StatTruncated = 2'd3;

	// what one packet byte produces: an optional word and an optional status
	typedef struct packed {
		logic        has_word;
		logic [4:0]  word_index;
		logic [31:0] word_value;
		logic        has_status;
		logic [1:0]  frame_status;
	} entry_t;

	// expected address string "/audio/frame"
	function automatic logic [7:0] addr_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h2f;
			4'd1:    c = 8'h61;
			4'd2:    c = 8'h75;
			4'd3:    c = 8'h64;
			4'd4:    c = 8'h69;
			4'd5:    c = 8'h6f;
			4'd6:    c = 8'h2f;
			4'd7:    c = 8'h66;
			4'd8:    c = 8'h72;
			4'd9:    c = 8'h61;
			4'd10:   c = 8'h6d;
			4'd11:   c = 8'h65;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> src/ofp_ifs.sv
// ofp channel interfaces: packet byte input and result output, valid/ready
// no dependencies
`default_nettype none

interface ofp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_packet;

	modport source (output valid, output data_byte, output end_of_packet, input ready);
	modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface ofp_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [4:0]  word_index;
	logic [31:0] word_value;
	logic [1:0]  frame_status;

	modport source (output valid, output result_kind, output word_index, output word_value,
		output frame_status, input ready);
	modport sink (input valid, input result_kind, input word_index, input word_value,
		input frame_status, output ready);
endinterface

`default_nettype wire

>>> src/osc_audio_frame_parser.sv
// path: a result passes the queue slot, the hold register and the output register; a status that
// follows a word on the final byte leaves the hold register after that word
// throughput: one byte per cycle unless the queue is full; the output side moves one result
// per cycle unless res.ready stalls it; the four-entry queue absorbs the extra status result
// reset: asynchronous, active low; parser returns to the address phase, queue and output empty
// top level: ofp_front -> ofp_queue -> ofp_back; depends on ofp_pkg and the channel interfaces
`default_nettype none

module osc_audio_frame_parser import ofp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	ofp_byte_if.sink     pkt,
	ofp_result_if.source res
);

	entry_t push_entry;
	entry_t head;
	logic   push;
	logic   full;
	logic   pop;
	logic   empty;

	ofp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt     (pkt),
		.q_full  (full),
		.q_push  (push),
		.q_entry (push_entry)
	);

	ofp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.empty      (empty)
	);

	ofp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_empty (empty),
		.q_pop   (pop),
		.res     (res)
	);

endmodule

`default_nettype wire

>>> src/ofp_front.sv
// ofp_front: byte parser; checks address and type tag, skips padding, assembles words
// depends on ofp_pkg and ofp_byte_if; pushes one entry per productive byte into the queue
`default_nettype none

module ofp_front import ofp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ofp_byte_if.sink   pkt,
	input  logic       q_full,
	output logic       q_push,
	output entry_t     q_entry
);

	localparam logic [2:0] PhAddr    = 3'd0;
	localparam logic [2:0] PhAddrPad = 3'd1;
	localparam logic [2:0] PhTag     = 3'd2;
	localparam logic [2:0] PhTagPad  = 3'd3;
	localparam logic [2:0] PhWords   = 3'd4;
	localparam logic [2:0] PhDone    = 3'd5;

	logic [2:0]        phase_q, phase_n;
	logic [5:0]        len_q, len_n;
	logic              addr_ok_q, addr_ok_n;
	logic              comma_q, comma_n;
	logic [1:0]        pad_q, pad_n;
	logic [23:0]       wbytes_q, wbytes_n;
	logic [1:0]        biw_q, biw_n;
	logic [4:0]        words_q, words_n;
	logic [1:0]        fail_q, fail_n;
	logic [TakenW-1:0] taken_q, taken_n;
	logic              acc;
	logic [7:0]        b;
	entry_t            ent;

	assign pkt.ready = !q_full;
	assign acc       = pkt.valid && !q_full;
	assign b         = pkt.data_byte;

	always_comb begin
		phase_n   = phase_q;
		len_n     = len_q;
		addr_ok_n = addr_ok_q;
		comma_n   = comma_q;
		pad_n     = pad_q;
		wbytes_n  = wbytes_q;
		biw_n     = biw_q;
		words_n   = words_q;
		fail_n    = fail_q;
		taken_n   = taken_q;
		ent       = '0;

		// bytes past the receive buffer size are dropped
		if (taken_q < TakenW'(MaxPacketBytes)) begin
			taken_n = taken_q + TakenW'(1);
			unique case (phase_q)
				PhAddr: begin
					if (b == 8'd0) begin
						if (!addr_ok_q || len_q != AddrLen) begin
							fail_n  = StatBadAddr;
							phase_n = PhDone;
						end else begin
							pad_n   = 2'd3 - len_q[1:0];
							len_n   = '0;
							phase_n = (pad_n != 2'd0) ? PhAddrPad : PhTag;
						end
					end else begin
						if (len_q >= AddrLen || addr_char(len_q[3:0]) != b)
							addr_ok_n = 1'b0;
						if (len_q < LenMax)
							len_n = len_q + 6'd1;
					end
				end
				PhTag: begin
					if (b == 8'd0) begin
						if (!comma_q || len_q != TagLen) begin
							fail_n  = StatBadTag;
							phase_n = PhDone;
						end else begin
							pad_n   = 2'd3 - len_q[1:0];
							len_n   = '0;
							phase_n = (pad_n != 2'd0) ? PhTagPad : PhWords;
						end
					end else begin
						if (len_q == 6'd0)
							comma_n = (b == TagComma);
						if (len_q < LenMax)
							len_n = len_q + 6'd1;
					end
				end
				PhAddrPad, PhTagPad: begin
					pad_n = pad_q - 2'd1;
					if (pad_n == 2'd0)
						phase_n = (phase_q == PhAddrPad) ? PhTag : PhWords;
				end
				PhWords: begin
					if (biw_q == 2'd3) begin
						ent.has_word   = 1'b1;
						ent.word_index = words_q;
						ent.word_value = {wbytes_q, b};
						wbytes_n       = '0;
						biw_n          = 2'd0;
						words_n        = words_q + 5'd1;
						if (words_n >= WordCount)
							phase_n = PhDone;
					end else begin
						wbytes_n = {wbytes_q[15:0], b};
						biw_n    = biw_q + 2'd1;
					end
				end
				default: begin
				end
			endcase
		end

		if (pkt.end_of_packet) begin
			ent.has_status = 1'b1;
			if (fail_n != StatOk)
				ent.frame_status = fail_n;
			else if (words_n >= WordCount)
				ent.frame_status = StatOk;
			else
				ent.frame_status = StatTruncated;
			// next packet starts from scratch
			phase_n   = PhAddr;
			len_n     = '0;
			addr_ok_n = 1'b1;
			comma_n   = 1'b0;
			pad_n     = '0;
			wbytes_n  = '0;
			biw_n     = '0;
			words_n   = '0;
			fail_n    = StatOk;
			taken_n   = '0;
		end
	end

	assign q_push  = acc && (ent.has_word || ent.has_status);
	assign q_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PhAddr;
			len_q     <= '0;
			addr_ok_q <= 1'b1;
			comma_q   <= 1'b0;
			pad_q     <= '0;
			wbytes_q  <= '0;
			biw_q     <= '0;
			words_q   <= '0;
			fail_q    <= StatOk;
			taken_q   <= '0;
		end else if (acc) begin
			phase_q   <= phase_n;
			len_q     <= len_n;
			addr_ok_q <= addr_ok_n;
			comma_q   <= comma_n;
			pad_q     <= pad_n;
			wbytes_q  <= wbytes_n;
			biw_q     <= biw_n;
			words_q   <= words_n;
			fail_q    <= fail_n;
			taken_q   <= taken_n;
		end
	end

endmodule

`default_nettype wire

>>> src/ofp_queue.sv
// ofp_queue: short fifo of parser entries between the front and back parts
// depends on ofp_pkg
`default_nettype none

module ofp_queue import ofp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);

	entry_t           slot_q [QueueDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == QCntW'(QueueDepth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPtrW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCntW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCntW'(1);
		end
	end

endmodule

`default_nettype wire

>>> src/ofp_back.sv
// ofp_back: splits queue entries into single results and drives the output register
// depends on ofp_pkg and ofp_result_if
`default_nettype none

module ofp_back import ofp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  entry_t       head,
	input  logic         q_empty,
	output logic         q_pop,
	ofp_result_if.source res
);

	entry_t      hold_q;
	logic        hw_q;
	logic        hs_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [4:0]  index_q;
	logic [31:0] value_q;
	logic [1:0]  status_q;
	logic        out_load;
	logic        hold_free;

	assign out_load  = !out_valid_q || res.ready;
	// hold is free now, or its last pending result leaves this cycle
	assign hold_free = (!hw_q && !hs_q) || (out_load && !(hw_q && hs_q));
	assign q_pop     = !q_empty && hold_free;

	always_ff @(posedge clk) begin
		if (q_pop)
			hold_q <= head;
		if (out_load) begin
			if (hw_q) begin
				kind_q   <= KindWord;
				index_q  <= hold_q.word_index;
				value_q  <= hold_q.word_value;
				status_q <= StatOk;
			end else begin
				kind_q   <= KindStatus;
				index_q  <= '0;
				value_q  <= '0;
				status_q <= hold_q.frame_status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q        <= 1'b0;
			hs_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= hw_q || hs_q;
			if (q_pop) begin
				hw_q <= head.has_word;
				hs_q <= head.has_status;
			end else if (out_load && hw_q) begin
				hw_q <= 1'b0;
			end else if (out_load && hs_q) begin
				hs_q <= 1'b0;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_kind  = kind_q;
	assign res.word_index   = index_q;
	assign res.word_value   = value_q;
	assign res.frame_status = status_q;

endmodule

`default_nettype wire

>>> src/ofp_checker.sv
// ofp_checker: port-level assertions for osc_audio_frame_parser, attached by bind
// depends on ofp_pkg
`default_nettype none

module ofp_checker import ofp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        result_kind,
	input logic [4:0]  word_index,
	input logic [31:0] word_value,
	input logic [1:0]  frame_status
);

	// a stalled transaction keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(word_value) && $stable(word_index)
		&& $stable(result_kind) && $stable(frame_status))
		else $error("result changed while stalled");

	a_word_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KindWord |-> frame_status == StatOk && word_index < 5'd24)
		else $error("bad word result fields");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && result_kind == KindStatus |-> word_index == 5'd0 && word_value == 32'd0)
		else $error("bad status result fields");

	// word indexes within a packet step by one
	a_word_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && result_kind == KindWord && word_index != 5'd23
		##1 res_valid && result_kind == KindWord
		|-> word_index == $past(word_index) + 5'd1 || $past(res_valid && !res_ready)
		|| ($past(res_valid) && $past(word_index) == word_index && !$past(res_ready)))
		else $error("word index out of order");

endmodule

bind osc_audio_frame_parser ofp_checker u_ofp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.result_kind  (res.result_kind),
	.word_index   (res.word_index),
	.word_value   (res.word_value),
	.frame_status (res.frame_status)
);

`default_nettype wire
